// ===== hdl/rtnh_pkg.sv =====
package rtnh_pkg;

  // Defaults for the top-level parameters.
  localparam int FRAC_BITS_DEF   = 16;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Triangles with an index at or above this count never hit.
  localparam int MAX_TRIANGLES = 65536;

  // Field widths.
  localparam int COORD_W = 32;
  localparam int DIR_W   = 18;
  localparam int IDX_W   = 16;
  localparam int UV_W    = 17;

  // Exact intermediate widths (signed).
  localparam int DIFF_W = COORD_W + 1;        // edge and offset components
  localparam int P_W    = 52;                 // d x e2
  localparam int Q_W    = 67;                 // s x e1
  localparam int DET_W  = 87;                 // p . e1
  localparam int PROD_W = Q_W + DIFF_W;       // one multiplier product
  localparam int ACC_W  = 102;                // dot-product accumulator

  // The divider produces this many quotient magnitude bits and flags
  // anything larger as overflow.
  localparam int QUO_BITS = 34;
  localparam int QUO_W    = QUO_BITS + 1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_DIR_X,
    REG_DIR_Y,
    REG_DIR_Z,
    REG_NEAR,
    REG_FAR
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]             tri_index;
    logic                         final_tri;
    logic                         idx_ok;
    logic [2:0][DIFF_W-1:0]       e1;
    logic [2:0][DIFF_W-1:0]       e2;
    logic [2:0][DIFF_W-1:0]       s;
  } tri_job_t;

  typedef struct packed {
    logic [2:0][DIR_W-1:0] dir;
    logic [COORD_W-1:0]    near_lim;
    logic [COORD_W-1:0]    far_lim;
  } ray_cfg_t;

  typedef struct packed {
    logic               hit_now;
    logic [COORD_W-1:0] hit_t;
    logic [UV_W-1:0]    hit_u;
    logic [UV_W-1:0]    hit_v;
    logic               any_hit;
    logic [IDX_W-1:0]   best_tri;
    logic               ray_done;
  } res_t;

endpackage

// ===== hdl/rtnh_if.sv =====
interface rtnh_in_if;
  logic                        valid;
  logic                        ready;
  logic [rtnh_pkg::IDX_W-1:0]  tri_index;
  logic signed [rtnh_pkg::COORD_W-1:0] a_x;
  logic signed [rtnh_pkg::COORD_W-1:0] a_y;
  logic signed [rtnh_pkg::COORD_W-1:0] a_z;
  logic signed [rtnh_pkg::COORD_W-1:0] b_x;
  logic signed [rtnh_pkg::COORD_W-1:0] b_y;
  logic signed [rtnh_pkg::COORD_W-1:0] b_z;
  logic signed [rtnh_pkg::COORD_W-1:0] c_x;
  logic signed [rtnh_pkg::COORD_W-1:0] c_y;
  logic signed [rtnh_pkg::COORD_W-1:0] c_z;
  logic                        final_tri;

  modport source (output valid, tri_index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                  final_tri, input ready);
  modport sink (input valid, tri_index, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                final_tri, output ready);
endinterface

interface rtnh_out_if;
  logic                                valid;
  logic                                ready;
  logic                                hit_now;
  logic signed [rtnh_pkg::COORD_W-1:0] hit_t;
  logic [rtnh_pkg::UV_W-1:0]           hit_u;
  logic [rtnh_pkg::UV_W-1:0]           hit_v;
  logic                                any_hit;
  logic [rtnh_pkg::IDX_W-1:0]          best_tri;
  logic                                ray_done;

  modport source (output valid, hit_now, hit_t, hit_u, hit_v, any_hit, best_tri, ray_done,
                  input ready);
  modport sink (input valid, hit_now, hit_t, hit_u, hit_v, any_hit, best_tri, ray_done,
                output ready);
endinterface

// ===== hdl/rtnh_front.sv =====
module rtnh_front (
  rtnh_in_if.sink                                in_tri,
  input  logic [2:0][rtnh_pkg::COORD_W-1:0]      origin,
  input  logic                                   q_full,
  output logic                                   push,
  output rtnh_pkg::tri_job_t                     job
);

  logic signed [rtnh_pkg::DIFF_W-1:0] ax [3];
  logic signed [rtnh_pkg::DIFF_W-1:0] bx [3];
  logic signed [rtnh_pkg::DIFF_W-1:0] cx [3];
  logic signed [rtnh_pkg::DIFF_W-1:0] ox [3];

  assign in_tri.ready = !q_full;
  assign push         = in_tri.valid && !q_full;

  always_comb begin
    ax[0] = rtnh_pkg::DIFF_W'(in_tri.a_x);
    ax[1] = rtnh_pkg::DIFF_W'(in_tri.a_y);
    ax[2] = rtnh_pkg::DIFF_W'(in_tri.a_z);
    bx[0] = rtnh_pkg::DIFF_W'(in_tri.b_x);
    bx[1] = rtnh_pkg::DIFF_W'(in_tri.b_y);
    bx[2] = rtnh_pkg::DIFF_W'(in_tri.b_z);
    cx[0] = rtnh_pkg::DIFF_W'(in_tri.c_x);
    cx[1] = rtnh_pkg::DIFF_W'(in_tri.c_y);
    cx[2] = rtnh_pkg::DIFF_W'(in_tri.c_z);
    for (int k = 0; k < 3; k++) begin
      ox[k] = rtnh_pkg::DIFF_W'($signed(origin[k]));
    end
    job.tri_index = in_tri.tri_index;
    job.final_tri = in_tri.final_tri;
    // Out-of-range indices are classified here and skip the arithmetic.
    job.idx_ok = (32'(in_tri.tri_index) < 32'(rtnh_pkg::MAX_TRIANGLES));
    for (int k = 0; k < 3; k++) begin
      job.e1[k] = bx[k] - ax[k];
      job.e2[k] = cx[k] - ax[k];
      job.s[k]  = ox[k] - ax[k];
    end
  end

endmodule

// ===== hdl/rtnh_fifo.sv =====
module rtnh_fifo #(
  parameter int DEPTH = rtnh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  rtnh_pkg::tri_job_t din,
  output logic               full,
  input  logic               pop,
  output logic               not_empty,
  output rtnh_pkg::tri_job_t dout
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  rtnh_pkg::tri_job_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full      = (cnt_r == CNT_W'(DEPTH));
  assign not_empty = (cnt_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign dout      = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hdl/rtnh_mul.sv =====
module rtnh_mul (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic signed [rtnh_pkg::Q_W-1:0]    a,
  input  logic signed [rtnh_pkg::DIFF_W-1:0] b,
  output logic                               done,
  output logic signed [rtnh_pkg::PROD_W-1:0] prod
);

  // Shift-and-add over the bits of b, the top bit carrying negative weight.
  localparam int B_W   = rtnh_pkg::DIFF_W;
  localparam int P_W   = rtnh_pkg::PROD_W;
  localparam int CNT_W = $clog2(B_W);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(B_W - 1);

  logic signed [P_W-1:0] acc_r;
  logic signed [P_W-1:0] ash_r;
  logic [B_W-1:0]        b_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;

  assign done = done_r;
  assign prod = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == LAST);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == LAST) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc_r <= '0;
      ash_r <= P_W'(a);
      b_r   <= b;
      cnt_r <= '0;
    end else if (busy_r) begin
      if (b_r[0]) begin
        acc_r <= (cnt_r == LAST) ? acc_r - ash_r : acc_r + ash_r;
      end
      ash_r <= ash_r <<< 1;
      b_r   <= b_r >> 1;
      cnt_r <= cnt_r + CNT_W'(1);
    end
  end

endmodule

// ===== hdl/rtnh_div.sv =====
module rtnh_div #(
  parameter int NUM_W = rtnh_pkg::ACC_W + rtnh_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic signed [NUM_W-1:0]           num,
  input  logic signed [rtnh_pkg::DET_W-1:0] den,
  output logic                              done,
  output logic                              ovf,
  output logic signed [rtnh_pkg::QUO_W-1:0] quo
);

  // Floor division, one quotient bit per cycle. A quotient whose
  // magnitude needs more than QB bits is only flagged.
  localparam int QB    = rtnh_pkg::QUO_BITS;
  localparam int QW    = rtnh_pkg::QUO_W;
  localparam int DW    = rtnh_pkg::DET_W;
  localparam int DSH_W = DW + QB - 1;
  localparam int CMP_W = (NUM_W > DW + QB) ? NUM_W : DW + QB;
  localparam int CNT_W = $clog2(QB);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(QB - 1);

  typedef enum logic [1:0] {D_IDLE, D_CHK, D_RUN, D_FIX} dstate_t;

  dstate_t              state_r;
  logic [NUM_W-1:0]     an_r;
  logic [DW-1:0]        bn_r;
  logic                 neg_r;
  logic [NUM_W-1:0]     rem_r;
  logic [DSH_W-1:0]     dsh_r;
  logic [QB-1:0]        q_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 ovf_r;
  logic [QW-1:0]        quo_r;
  logic                 done_r;

  logic                 big;
  logic                 ge;
  logic [QW-1:0]        q_up;

  assign big  = CMP_W'(an_r) >= (CMP_W'(bn_r) << QB);
  assign ge   = CMP_W'(rem_r) >= CMP_W'(dsh_r);
  assign q_up = QW'(q_r) + QW'(rem_r != '0);

  assign done = done_r;
  assign ovf  = ovf_r;
  assign quo  = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= D_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= (state_r == D_FIX);
      case (state_r)
        D_IDLE: begin
          if (start) begin
            an_r    <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
            bn_r    <= den[DW-1] ? DW'(-den) : DW'(den);
            neg_r   <= num[NUM_W-1] ^ den[DW-1];
            state_r <= D_CHK;
          end
        end
        D_CHK: begin
          ovf_r   <= big;
          rem_r   <= an_r;
          dsh_r   <= DSH_W'(bn_r) << (QB - 1);
          q_r     <= '0;
          cnt_r   <= '0;
          state_r <= big ? D_FIX : D_RUN;
        end
        D_RUN: begin
          if (ge) begin
            rem_r <= NUM_W'(CMP_W'(rem_r) - CMP_W'(dsh_r));
          end
          q_r   <= {q_r[QB-2:0], ge};
          dsh_r <= dsh_r >> 1;
          cnt_r <= cnt_r + CNT_W'(1);
          if (cnt_r == LAST) begin
            state_r <= D_FIX;
          end
        end
        D_FIX: begin
          quo_r   <= neg_r ? -q_up : QW'(q_r);
          state_r <= D_IDLE;
        end
        default: begin
          state_r <= D_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/rtnh_back.sv =====
module rtnh_back #(
  parameter int FRAC_BITS = rtnh_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                job_valid,
  input  rtnh_pkg::tri_job_t                  job,
  output logic                                job_pop,
  input  rtnh_pkg::ray_cfg_t                  ray,
  input  logic                                far_wr,
  input  logic [rtnh_pkg::COORD_W-1:0]        far_new,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rtnh_pkg::res_t                      res
);

  localparam int Q_W    = rtnh_pkg::Q_W;
  localparam int B_W    = rtnh_pkg::DIFF_W;
  localparam int P_W    = rtnh_pkg::P_W;
  localparam int DET_W  = rtnh_pkg::DET_W;
  localparam int ACC_W  = rtnh_pkg::ACC_W;
  localparam int QUO_W  = rtnh_pkg::QUO_W;
  localparam int NUM_W  = ACC_W + FRAC_BITS;
  localparam int CW     = rtnh_pkg::COORD_W;

  // Sequencer positions: 24 products make p, q, det and the three
  // numerators; a division follows each numerator.
  localparam logic [4:0] STEP_DET = 5'd14;
  localparam logic [4:0] STEP_U   = 5'd17;
  localparam logic [4:0] STEP_V   = 5'd20;
  localparam logic [4:0] STEP_T   = 5'd23;

  localparam logic signed [QUO_W-1:0] ONE_Q = QUO_W'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [QUO_W-1:0] T_HI  = QUO_W'(64'sd2147483647);
  localparam logic signed [QUO_W-1:0] T_LO  = QUO_W'(-64'sd2147483648);

  typedef enum logic [2:0] {
    B_IDLE, B_MUL_GO, B_MUL_WAIT, B_DIV_GO, B_DIV_WAIT, B_DONE
  } bstate_t;

  bstate_t                  state_r;
  rtnh_pkg::tri_job_t       job_r;
  logic [4:0]               step_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic signed [P_W-1:0]    p_r [3];
  logic signed [Q_W-1:0]    q_r [3];
  logic signed [DET_W-1:0]  det_r;
  logic signed [QUO_W-1:0]  u_r, v_r, t_r;
  logic                     u_ovf_r, v_ovf_r, t_ovf_r;
  logic                     miss_r;

  logic signed [CW-1:0]     nearest_t_r;
  logic [rtnh_pkg::UV_W-1:0] nearest_u_r, nearest_v_r;
  logic                     hit_seen_r;
  logic [rtnh_pkg::IDX_W-1:0] nearest_idx_r;
  logic                     out_valid_r;
  rtnh_pkg::res_t           res_r;

  logic signed [Q_W-1:0]    op_a;
  logic signed [B_W-1:0]    op_b;
  logic                     op_first, op_neg;
  logic signed [Q_W-1:0]    da [3];
  logic signed [B_W-1:0]    db [3], e1b [3], e2b [3], sb [3];

  logic                     mul_start, mul_done;
  logic signed [rtnh_pkg::PROD_W-1:0] mul_prod;
  logic                     div_start, div_done, div_ovf;
  logic signed [QUO_W-1:0]  div_quo;
  logic signed [NUM_W-1:0]  div_num;
  logic signed [ACC_W-1:0]  acc_sum;
  logic signed [ACC_W-1:0]  prod_ext;

  logic                     u_ok, v_ok, uv_ok, t_ok, hit;
  logic signed [CW-1:0]     t32;
  logic                     out_free;
  logic                     out_load;

  assign job_pop   = (state_r == B_IDLE) && job_valid;
  assign mul_start = (state_r == B_MUL_GO);
  assign div_start = (state_r == B_DIV_GO);
  assign div_num   = NUM_W'(acc_r) <<< FRAC_BITS;
  assign out_valid = out_valid_r;
  assign res       = res_r;
  assign out_free  = !out_valid_r || out_ready;
  assign out_load  = (state_r == B_DONE) && out_free;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      da[k]  = Q_W'($signed(ray.dir[k]));
      db[k]  = B_W'($signed(ray.dir[k]));
      e1b[k] = $signed(job_r.e1[k]);
      e2b[k] = $signed(job_r.e2[k]);
      sb[k]  = $signed(job_r.s[k]);
    end
  end

  // Operand table of the product sequence.
  always_comb begin
    op_a     = '0;
    op_b     = '0;
    op_first = 1'b0;
    op_neg   = 1'b0;
    case (step_r)
      5'd0:  begin op_a = da[1]; op_b = e2b[2]; op_first = 1'b1; end
      5'd1:  begin op_a = da[2]; op_b = e2b[1]; op_neg = 1'b1; end
      5'd2:  begin op_a = da[2]; op_b = e2b[0]; op_first = 1'b1; end
      5'd3:  begin op_a = da[0]; op_b = e2b[2]; op_neg = 1'b1; end
      5'd4:  begin op_a = da[0]; op_b = e2b[1]; op_first = 1'b1; end
      5'd5:  begin op_a = da[1]; op_b = e2b[0]; op_neg = 1'b1; end
      5'd6:  begin op_a = Q_W'(sb[1]); op_b = e1b[2]; op_first = 1'b1; end
      5'd7:  begin op_a = Q_W'(sb[2]); op_b = e1b[1]; op_neg = 1'b1; end
      5'd8:  begin op_a = Q_W'(sb[2]); op_b = e1b[0]; op_first = 1'b1; end
      5'd9:  begin op_a = Q_W'(sb[0]); op_b = e1b[2]; op_neg = 1'b1; end
      5'd10: begin op_a = Q_W'(sb[0]); op_b = e1b[1]; op_first = 1'b1; end
      5'd11: begin op_a = Q_W'(sb[1]); op_b = e1b[0]; op_neg = 1'b1; end
      5'd12: begin op_a = Q_W'(p_r[0]); op_b = e1b[0]; op_first = 1'b1; end
      5'd13: begin op_a = Q_W'(p_r[1]); op_b = e1b[1]; end
      5'd14: begin op_a = Q_W'(p_r[2]); op_b = e1b[2]; end
      5'd15: begin op_a = Q_W'(p_r[0]); op_b = sb[0]; op_first = 1'b1; end
      5'd16: begin op_a = Q_W'(p_r[1]); op_b = sb[1]; end
      5'd17: begin op_a = Q_W'(p_r[2]); op_b = sb[2]; end
      5'd18: begin op_a = q_r[0]; op_b = db[0]; op_first = 1'b1; end
      5'd19: begin op_a = q_r[1]; op_b = db[1]; end
      5'd20: begin op_a = q_r[2]; op_b = db[2]; end
      5'd21: begin op_a = q_r[0]; op_b = e2b[0]; op_first = 1'b1; end
      5'd22: begin op_a = q_r[1]; op_b = e2b[1]; end
      5'd23: begin op_a = q_r[2]; op_b = e2b[2]; end
      default: begin
        op_a = '0;
      end
    endcase
  end

  assign prod_ext = ACC_W'(mul_prod);
  assign acc_sum  = (op_first ? '0 : acc_r) + (op_neg ? -prod_ext : prod_ext);

  // Acceptance tests on the quantized quotients.
  always_comb begin
    t32   = t_r[CW-1:0];
    u_ok  = !u_ovf_r && (u_r >= 0) && (u_r <= ONE_Q);
    v_ok  = !v_ovf_r && (v_r >= 0) && (v_r <= ONE_Q);
    uv_ok = (u_r + v_r) <= ONE_Q;
    t_ok  = !t_ovf_r && (t_r >= T_LO) && (t_r <= T_HI);
    hit   = !miss_r && u_ok && v_ok && uv_ok && t_ok &&
            (t32 >= $signed(ray.near_lim)) && (t32 <= nearest_t_r);
  end

  rtnh_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (op_a),
    .b     (op_b),
    .done  (mul_done),
    .prod  (mul_prod)
  );

  rtnh_div #(.NUM_W(NUM_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (det_r),
    .done  (div_done),
    .ovf   (div_ovf),
    .quo   (div_quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_IDLE;
      out_valid_r   <= 1'b0;
      nearest_t_r   <= 32'sh7FFF_FFFF;
      nearest_u_r   <= '0;
      nearest_v_r   <= '0;
      hit_seen_r    <= 1'b0;
      nearest_idx_r <= '0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (far_wr) begin
        nearest_t_r   <= $signed(far_new);
        nearest_u_r   <= '0;
        nearest_v_r   <= '0;
        hit_seen_r    <= 1'b0;
        nearest_idx_r <= '0;
      end
      case (state_r)
        B_IDLE: begin
          if (job_valid) begin
            job_r   <= job;
            step_r  <= '0;
            miss_r  <= !job.idx_ok;
            state_r <= job.idx_ok ? B_MUL_GO : B_DONE;
          end
        end
        B_MUL_GO: begin
          state_r <= B_MUL_WAIT;
        end
        B_MUL_WAIT: begin
          if (mul_done) begin
            acc_r <= acc_sum;
            case (step_r)
              5'd1:  p_r[0] <= P_W'(acc_sum);
              5'd3:  p_r[1] <= P_W'(acc_sum);
              5'd5:  p_r[2] <= P_W'(acc_sum);
              5'd7:  q_r[0] <= Q_W'(acc_sum);
              5'd9:  q_r[1] <= Q_W'(acc_sum);
              5'd11: q_r[2] <= Q_W'(acc_sum);
              default: begin
              end
            endcase
            if (step_r == STEP_DET) begin
              det_r <= DET_W'(acc_sum);
            end
            if (step_r == STEP_DET && acc_sum == '0) begin
              // A degenerate triangle or a ray parallel to its plane.
              miss_r  <= 1'b1;
              state_r <= B_DONE;
            end else if (step_r == STEP_U || step_r == STEP_V || step_r == STEP_T) begin
              state_r <= B_DIV_GO;
            end else begin
              step_r  <= step_r + 5'd1;
              state_r <= B_MUL_GO;
            end
          end
        end
        B_DIV_GO: begin
          state_r <= B_DIV_WAIT;
        end
        B_DIV_WAIT: begin
          if (div_done) begin
            if (step_r == STEP_U) begin
              u_r <= div_quo; u_ovf_r <= div_ovf;
            end else if (step_r == STEP_V) begin
              v_r <= div_quo; v_ovf_r <= div_ovf;
            end else begin
              t_r <= div_quo; t_ovf_r <= div_ovf;
            end
            if (step_r == STEP_T) begin
              state_r <= B_DONE;
            end else begin
              step_r  <= step_r + 5'd1;
              state_r <= B_MUL_GO;
            end
          end
        end
        B_DONE: begin
          if (out_free) begin
            res_r.hit_now    <= hit;
            res_r.hit_t      <= hit ? t32 : nearest_t_r;
            res_r.hit_u      <= hit ? u_r[rtnh_pkg::UV_W-1:0] : nearest_u_r;
            res_r.hit_v      <= hit ? v_r[rtnh_pkg::UV_W-1:0] : nearest_v_r;
            res_r.any_hit    <= hit || hit_seen_r;
            res_r.best_tri   <= hit ? job_r.tri_index : nearest_idx_r;
            res_r.ray_done   <= job_r.final_tri;
            if (job_r.final_tri) begin
              nearest_t_r   <= $signed(ray.far_lim);
              nearest_u_r   <= '0;
              nearest_v_r   <= '0;
              hit_seen_r    <= 1'b0;
              nearest_idx_r <= '0;
            end else if (hit) begin
              nearest_t_r   <= t32;
              nearest_u_r   <= u_r[rtnh_pkg::UV_W-1:0];
              nearest_v_r   <= v_r[rtnh_pkg::UV_W-1:0];
              hit_seen_r    <= 1'b1;
              nearest_idx_r <= job_r.tri_index;
            end
            state_r <= B_IDLE;
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/ray_triangle_nearest_hit.sv =====
// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+---------------------------------------
// in_tri   | in        | valid/ready          | triangle index, three vertices, last flag
// out_hit  | out       | valid/ready          | nearest hit so far and this triangle's verdict
// cfg      | in        | cfg_we, no stall     | ray origin, direction, near and far limits
//
// A triangle needs 24 products through one bit-serial multiplier and three
// floor divisions at one quotient bit per cycle. A zero determinant ends the
// work after the det product, and an index beyond the mesh size skips the
// products and divisions. Reset is synchronous and active low; it restores
// the register defaults. The input queue keeps taking words until it is full
// while the sequencer works, and a result waiting in the output register
// stalls only the final step of the next one.

module ray_triangle_nearest_hit #(
  parameter int FRAC_BITS   = rtnh_pkg::FRAC_BITS_DEF,
  parameter int QUEUE_DEPTH = rtnh_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  rtnh_in_if.sink                             in_tri,
  rtnh_out_if.source                          out_hit,
  input  logic                                cfg_we,
  input  logic [rtnh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rtnh_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int CW = rtnh_pkg::COORD_W;
  localparam int DW = rtnh_pkg::DIR_W;

  // Ray registers. The direction resets to one unit along z.
  logic [2:0][CW-1:0] origin_r;
  logic [2:0][DW-1:0] dir_r;
  logic [CW-1:0]      near_r;
  logic [CW-1:0]      far_r;

  rtnh_pkg::ray_cfg_t ray;
  rtnh_pkg::tri_job_t front_job;
  rtnh_pkg::tri_job_t q_job;
  rtnh_pkg::res_t     res;
  logic               push, q_full, q_valid, q_pop;
  logic               far_wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_r <= '0;
      dir_r[0] <= '0;
      dir_r[1] <= '0;
      dir_r[2] <= DW'(64'd1 << FRAC_BITS);
      near_r   <= '0;
      far_r    <= 32'h7FFF_FFFF;
    end else if (cfg_we) begin
      case (rtnh_pkg::cfg_reg_t'(cfg_index))
        rtnh_pkg::REG_ORIGIN_X: origin_r[0] <= cfg_data[CW-1:0];
        rtnh_pkg::REG_ORIGIN_Y: origin_r[1] <= cfg_data[CW-1:0];
        rtnh_pkg::REG_ORIGIN_Z: origin_r[2] <= cfg_data[CW-1:0];
        rtnh_pkg::REG_DIR_X:    dir_r[0]    <= cfg_data[DW-1:0];
        rtnh_pkg::REG_DIR_Y:    dir_r[1]    <= cfg_data[DW-1:0];
        rtnh_pkg::REG_DIR_Z:    dir_r[2]    <= cfg_data[DW-1:0];
        rtnh_pkg::REG_NEAR:     near_r      <= cfg_data[CW-1:0];
        rtnh_pkg::REG_FAR:      far_r       <= cfg_data[CW-1:0];
        default: begin
        end
      endcase
    end
  end

  // A far-limit write also restarts the ray in the back end.
  assign far_wr = cfg_we && (rtnh_pkg::cfg_reg_t'(cfg_index) == rtnh_pkg::REG_FAR);

  always_comb begin
    ray.dir      = dir_r;
    ray.near_lim = near_r;
    ray.far_lim  = far_r;
  end

  // The front end forms edges and the origin offset and sorts out bad indices.
  rtnh_front u_front (
    .in_tri (in_tri),
    .origin (origin_r),
    .q_full (q_full),
    .push   (push),
    .job    (front_job)
  );

  rtnh_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .din       (front_job),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .dout      (q_job)
  );

  // The back end runs the intersection test and keeps the nearest hit.
  rtnh_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (q_valid),
    .job       (q_job),
    .job_pop   (q_pop),
    .ray       (ray),
    .far_wr    (far_wr),
    .far_new   (cfg_data[CW-1:0]),
    .out_valid (out_hit.valid),
    .out_ready (out_hit.ready),
    .res       (res)
  );

  assign out_hit.hit_now  = res.hit_now;
  assign out_hit.hit_t    = res.hit_t;
  assign out_hit.hit_u    = res.hit_u;
  assign out_hit.hit_v    = res.hit_v;
  assign out_hit.any_hit  = res.any_hit;
  assign out_hit.best_tri = res.best_tri;
  assign out_hit.ray_done = res.ray_done;

endmodule

// ===== hdl/rtnh_checker.sv =====
module rtnh_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic                         hit_now,
  input logic                         any_hit,
  input logic [rtnh_pkg::UV_W-1:0]    hit_u,
  input logic [rtnh_pkg::UV_W-1:0]    hit_v,
  input logic [rtnh_pkg::IDX_W-1:0]   best_tri
);

  // A result word stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped before it was taken");

  // A fresh nearest hit always shows up as a hit of the ray.
  a_hit_any: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && hit_now |-> any_hit)
    else $error("hit_now without any_hit");

  // Without any hit the barycentrics and index keep their cleared values.
  a_no_hit_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !any_hit |-> hit_u == '0 && hit_v == '0 && best_tri == '0)
    else $error("stale hit data while no hit was seen");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word offered right after reset");

endmodule

bind ray_triangle_nearest_hit rtnh_checker u_rtnh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_hit.valid),
  .out_ready (out_hit.ready),
  .hit_now   (out_hit.hit_now),
  .any_hit   (out_hit.any_hit),
  .hit_u     (out_hit.hit_u),
  .hit_v     (out_hit.hit_v),
  .best_tri  (out_hit.best_tri)
);
